[hdl/aus_pkg.sv]
package aus_pkg;

   localparam int PHASE_FRAC_BITS = 16;
   localparam int ALPHA_FRAC_BITS = 16;
   localparam int MAX_RESULTS     = 64;

   localparam int SAMPLE_W    = 16;
   localparam int BYTE_W      = 8;
   localparam int MODE_W      = 1;
   localparam int STEP_W      = 19;
   localparam int ALPHA_W     = 17;
   localparam int TOTAL_W     = 24;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;

   localparam int PHASE_W = ((STEP_W > PHASE_FRAC_BITS) ? STEP_W : PHASE_FRAC_BITS + 1) + 1;
   localparam int COUNT_W = $clog2(MAX_RESULTS + 1);

   typedef logic [SAMPLE_W-1:0]        sample_type;
   typedef logic signed [SAMPLE_W-1:0] out_sample_type;
   typedef logic [STEP_W-1:0]          step_type;
   typedef logic [ALPHA_W-1:0]         alpha_type;
   typedef logic [TOTAL_W-1:0]         total_type;
   typedef logic [PHASE_W-1:0]         phase_type;
   typedef logic [COUNT_W-1:0]         count_type;
   typedef logic [CSR_INDEX_W-1:0]     csr_index_type;
   typedef logic [CSR_DATA_W-1:0]      csr_data_type;

   localparam csr_index_type CSR_SAMPLE_WIDTH_MODE = CSR_INDEX_W'(0);
   localparam csr_index_type CSR_RESAMPLE_STEP     = CSR_INDEX_W'(1);
   localparam csr_index_type CSR_FILTER_ALPHA      = CSR_INDEX_W'(2);
   localparam csr_index_type CSR_OUTPUT_TOTAL      = CSR_INDEX_W'(3);

   localparam logic [MODE_W-1:0] RESET_MODE  = MODE_W'(0);
   localparam step_type          RESET_STEP  = STEP_W'(16384);
   localparam alpha_type         RESET_ALPHA = ALPHA_W'(28830);
   localparam total_type         RESET_TOTAL = TOTAL_W'(2);

   localparam count_type COUNT_MAX   = COUNT_W'(MAX_RESULTS);
   localparam count_type COUNT_FINAL = COUNT_W'(MAX_RESULTS - 1);

   typedef struct packed {
      logic accept;
      logic first_store;
      logic hold_sel;
      logic mul_a;
      logic sum_a;
      logic mul_b;
      logic emit;
      logic force_last;
      logic seg_end;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic have_prev;
      logic last;
      logic seg_go;
      logic hold_go;
      logic rsp_free;
   } status_type;

endpackage

[hdl/aus_req_if.sv]
interface aus_req_if;
   logic                 valid;
   logic                 ready;
   aus_pkg::sample_type  source_sample;
   logic                 source_last;

   modport source (output valid, output source_sample, output source_last, input ready);
   modport sink (input valid, input source_sample, input source_last, output ready);
endinterface

[hdl/aus_rsp_if.sv]
interface aus_rsp_if;
   logic                    valid;
   logic                    ready;
   aus_pkg::out_sample_type out_sample;
   logic                    out_last;

   modport source (output valid, output out_sample, output out_last, input ready);
   modport sink (input valid, input out_sample, input out_last, output ready);
endinterface

[hdl/aus_ctrl.sv]
module aus_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  aus_pkg::status_type status,
   output aus_pkg::cmd_type    cmd
);
   import aus_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SEG_CHK,
      ST_HOLD_CHK,
      ST_MUL_A,
      ST_SUM_A,
      ST_MUL_B,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   logic      hold_ff, hold_in;
   logic      below_limit;

   assign below_limit = (count_ff < COUNT_MAX);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      hold_in   = hold_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               count_in   = '0;
               hold_in    = 1'b0;
               state_in   = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!status.have_prev) begin
               cmd.first_store = 1'b1;
               if (status.last) begin
                  hold_in  = 1'b1;
                  state_in = ST_HOLD_CHK;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_SEG_CHK;
            end
         end
         ST_SEG_CHK: begin
            if (status.seg_go && below_limit) begin
               state_in = ST_MUL_A;
            end else begin
               cmd.seg_end = 1'b1;
               if (status.last) begin
                  hold_in  = 1'b1;
                  state_in = ST_HOLD_CHK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_HOLD_CHK: begin
            if (status.hold_go && below_limit) begin
               state_in = ST_MUL_A;
            end else begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_MUL_A: begin
            cmd.mul_a    = 1'b1;
            cmd.hold_sel = hold_ff;
            state_in     = ST_SUM_A;
         end
         ST_SUM_A: begin
            cmd.sum_a = 1'b1;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit       = 1'b1;
               cmd.hold_sel   = hold_ff;
               cmd.force_last = status.last && (count_ff == COUNT_FINAL);
               count_in       = count_ff + COUNT_W'(1);
               state_in       = hold_ff ? ST_HOLD_CHK : ST_SEG_CHK;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         hold_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         hold_ff  <= hold_in;
      end
   end

endmodule

[hdl/aus_datapath.sv]
module aus_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  aus_pkg::csr_index_type  csr_index,
   input  aus_pkg::csr_data_type   csr_write_data,
   input  aus_pkg::sample_type     req_sample,
   input  logic                    req_last,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output aus_pkg::out_sample_type rsp_sample,
   output logic                    rsp_last,
   input  aus_pkg::cmd_type        cmd,
   output aus_pkg::status_type     status
);
   import aus_pkg::*;

   localparam int EXT_W    = SAMPLE_W + 1;
   localparam int PROD_A_W = EXT_W + PHASE_FRAC_BITS + 1;
   localparam int NUM_A_W  = PROD_A_W + 1;
   localparam int PROD_B_W = ALPHA_W + 1 + EXT_W;
   localparam int NUM_B_W  = PROD_B_W + 1;

   localparam phase_type PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;
   localparam alpha_type ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC_BITS;
   localparam logic signed [NUM_A_W-1:0] ROUND_A = NUM_A_W'((1 << PHASE_FRAC_BITS) - 1);
   localparam logic signed [NUM_B_W-1:0] ROUND_B = NUM_B_W'((1 << ALPHA_FRAC_BITS) - 1);

   logic [MODE_W-1:0] mode_ff, mode_in;
   step_type          step_ff, step_in;
   alpha_type         alpha_ff, alpha_in;
   total_type         total_ff, total_in;

   sample_type     cur_ff, cur_in;
   logic           last_ff, last_in;
   sample_type     prev_ff, prev_in;
   logic           have_prev_ff, have_prev_in;
   phase_type      phase_ff, phase_in;
   total_type      emitted_ff, emitted_in;
   out_sample_type mem_ff, mem_in;

   logic signed [EXT_W-1:0]    sa_ff, sa_in;
   logic signed [PROD_A_W-1:0] prod_a_ff, prod_a_in;
   out_sample_type             x_ff, x_in;
   logic signed [PROD_B_W-1:0] prod_b_ff, prod_b_in;

   logic           rsp_valid_ff, rsp_valid_in;
   out_sample_type rsp_sample_ff, rsp_sample_in;
   logic           rsp_last_ff, rsp_last_in;

   sample_type                  a_raw;
   logic signed [EXT_W-1:0]     sa, sb, diff, err;
   logic [PHASE_FRAC_BITS-1:0]  frac;
   logic signed [NUM_A_W-1:0]   num_a, num_a_adj, x_full;
   logic [BYTE_W-1:0]           lin;
   alpha_type                   alpha_sat;
   logic signed [NUM_B_W-1:0]   num_b, num_b_adj, y_full;
   out_sample_type              y;
   logic [TOTAL_W:0]            emitted_next;
   logic                        rsp_free;

   always_comb begin
      a_raw = cmd.hold_sel ? cur_ff : prev_ff;
      frac  = cmd.hold_sel ? '0 : phase_ff[PHASE_FRAC_BITS-1:0];
      if (mode_ff[0]) begin
         sa = $signed({a_raw[SAMPLE_W-1], a_raw});
         sb = $signed({cur_ff[SAMPLE_W-1], cur_ff});
      end else begin
         sa = $signed({{(EXT_W-BYTE_W){1'b0}}, a_raw[BYTE_W-1:0]});
         sb = $signed({{(EXT_W-BYTE_W){1'b0}}, cur_ff[BYTE_W-1:0]});
      end
      diff      = sb - sa;
      prod_a_in = diff * $signed({1'b0, frac});
      sa_in     = sa;

      num_a     = (NUM_A_W'(sa_ff) <<< PHASE_FRAC_BITS) + NUM_A_W'(prod_a_ff);
      num_a_adj = num_a[NUM_A_W-1] ? (num_a + ROUND_A) : num_a;
      x_full    = num_a_adj >>> PHASE_FRAC_BITS;
      lin       = x_full[BYTE_W-1:0];
      if (mode_ff[0]) begin
         x_in = x_full[SAMPLE_W-1:0];
      end else begin
         x_in = {~lin[BYTE_W-1], lin[BYTE_W-2:0], lin};
      end

      alpha_sat = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
      err       = EXT_W'(x_ff) - EXT_W'(mem_ff);
      prod_b_in = $signed({1'b0, alpha_sat}) * err;

      num_b     = (NUM_B_W'(mem_ff) <<< ALPHA_FRAC_BITS) + NUM_B_W'(prod_b_ff);
      num_b_adj = num_b[NUM_B_W-1] ? (num_b + ROUND_B) : num_b;
      y_full    = num_b_adj >>> ALPHA_FRAC_BITS;
      y         = (emitted_ff == '0) ? x_ff : y_full[SAMPLE_W-1:0];

      emitted_next = {1'b0, emitted_ff} + (TOTAL_W + 1)'(1);
      rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      mode_in      = mode_ff;
      step_in      = step_ff;
      alpha_in     = alpha_ff;
      total_in     = total_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      phase_in     = phase_ff;
      emitted_in   = emitted_ff;
      mem_in       = mem_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SAMPLE_WIDTH_MODE: mode_in  = csr_write_data[MODE_W-1:0];
            CSR_RESAMPLE_STEP:     step_in  = csr_write_data[STEP_W-1:0];
            CSR_FILTER_ALPHA:      alpha_in = csr_write_data[ALPHA_W-1:0];
            CSR_OUTPUT_TOTAL:      total_in = csr_write_data[TOTAL_W-1:0];
         endcase
      end

      if (cmd.accept) begin
         cur_in  = req_sample;
         last_in = req_last;
      end

      if (cmd.first_store) begin
         prev_in      = cur_ff;
         have_prev_in = 1'b1;
         phase_in     = '0;
      end

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = y;
         rsp_last_in   = (emitted_next == {1'b0, total_ff}) || cmd.force_last;
         mem_in        = y;
         emitted_in    = emitted_next[TOTAL_W-1:0];
         if (!cmd.hold_sel) begin
            phase_in = phase_ff + PHASE_W'(step_ff);
         end
      end

      if (cmd.seg_end) begin
         prev_in  = cur_ff;
         phase_in = (phase_ff >= PHASE_ONE) ? (phase_ff - PHASE_ONE) : '0;
      end

      if (cmd.clear) begin
         prev_in      = '0;
         have_prev_in = 1'b0;
         phase_in     = '0;
         emitted_in   = '0;
         mem_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= RESET_MODE;
         step_ff      <= RESET_STEP;
         alpha_ff     <= RESET_ALPHA;
         total_ff     <= RESET_TOTAL;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         phase_ff     <= '0;
         emitted_ff   <= '0;
         mem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         step_ff      <= step_in;
         alpha_ff     <= alpha_in;
         total_ff     <= total_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         phase_ff     <= phase_in;
         emitted_ff   <= emitted_in;
         mem_ff       <= mem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      last_ff       <= last_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      if (cmd.mul_a) begin
         sa_ff     <= sa_in;
         prod_a_ff <= prod_a_in;
      end
      if (cmd.sum_a) begin
         x_ff <= x_in;
      end
      if (cmd.mul_b) begin
         prod_b_ff <= prod_b_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

   assign status.have_prev = have_prev_ff;
   assign status.last      = last_ff;
   assign status.seg_go    = (emitted_ff < total_ff) && (phase_ff < PHASE_ONE);
   assign status.hold_go   = (emitted_ff < total_ff);
   assign status.rsp_free  = rsp_free;

endmodule

[hdl/audio_upsampler_with_lowpass.sv]
// Channel   Direction  Payload                                Transaction when
// req_chan  in         source_sample[15:0], source_last        valid and ready high
// rsp_chan  out        out_sample[15:0] signed, out_last       valid and ready high
// csr_*     in         csr_index[1:0], csr_write_data[23:0]    csr_write_enable high
//
// An input transaction is accepted and decided on; each result it yields passes a
// segment check, interpolation multiply, sum, filter multiply and emit, and with
// a previous sample held, a segment check ends the segment; the final sample of
// a sound adds a hold check. The interpolation and filter multipliers take turns.
// Reset is synchronous; it returns the CSRs to their defaults and the sound to
// its start. A stalled result waits in the output register; a new input transaction
// is taken meanwhile, but the next result waits until the register is free.
module audio_upsampler_with_lowpass (
   input  logic                   clock,
   input  logic                   reset,
   aus_req_if.sink                req_chan,
   aus_rsp_if.source              rsp_chan,
   input  logic                   csr_write_enable,
   input  aus_pkg::csr_index_type csr_index,
   input  aus_pkg::csr_data_type  csr_write_data
);
   import aus_pkg::*;

   cmd_type    cmd;
   status_type status;

   aus_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   aus_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_sample       (req_chan.source_sample),
      .req_last         (req_chan.source_last),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_sample       (rsp_chan.out_sample),
      .rsp_last         (rsp_chan.out_last),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
